>>> src/skvt_pkg.sv
// Shared types and constants for the sorted key/value table.
// Used by skvt_cmp and sorted_key_value_table; depends on nothing.
`default_nettype none

package skvt_pkg;

    localparam int KEY_W        = 32;
    localparam int VAL_W        = 64;
    localparam int ENTRY_W      = KEY_W + VAL_W;
    localparam int COUNT_W      = 7;
    localparam int KIND_W       = 2;
    localparam int IN_DATA_W    = 96;
    localparam int OUT_DATA_W   = 104;
    localparam int CAPACITY_DEF = 64;

    typedef enum logic [KIND_W-1:0] {
        KIND_INSERT = 2'd0,
        KIND_DELETE = 2'd1,
        KIND_SEARCH = 2'd2,
        KIND_CLEAR  = 2'd3
    } t_kind;

    // Result of the shared key comparator.
    typedef struct packed {
        logic eq;
        logic less;
    } t_cmp;

endpackage

`default_nettype wire

>>> src/skvt_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; takes no package.
`default_nettype none

module skvt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

>>> src/skvt_cmp.sv
// Shared key comparator: equality and signed less-than of two keys.
// Depends on skvt_pkg for the key width and the result struct.
`default_nettype none

module skvt_cmp (
    input  wire logic [skvt_pkg::KEY_W-1:0] i_a,
    input  wire logic [skvt_pkg::KEY_W-1:0] i_b,
    output skvt_pkg::t_cmp                  o_cmp
);

    always_comb begin
        o_cmp.eq   = (i_a == i_b);
        o_cmp.less = ($signed(i_a) < $signed(i_b));
    end

endmodule

`default_nettype wire

>>> src/sorted_key_value_table.sv
// Top level of the sorted key/value table: sequencer, entry RAM and comparator.
// Depends on skvt_pkg, skvt_ram and skvt_cmp.
//
// The table holds up to CAPACITY entries (signed 32-bit key, 64-bit value) in
// ascending key order in one RAM. A request is one transfer on the slave
// stream: tuser carries the kind (insert, delete, search, clear), tdata the
// key and value. Exactly one result transfer follows on the master stream.
// The block works on one request at a time; the RAM reads and writes one entry
// per cycle. Clear, an insert into a full table and any request on an empty
// table go straight to the result; the others step the single RAM port
// through the stored entries. Insert walks down from the tail,
// shifting each larger-or-equal entry up by one until it reaches the slot of
// the new key. Delete and search walk up from the head to the first matching
// key; delete then moves every later entry down by one. A finished result sits
// in an output register, so the next request is taken while it waits; that
// request then holds in its last cycle until the waiting result has left.
`default_nettype none

module sorted_key_value_table #(
    parameter int CAPACITY = skvt_pkg::CAPACITY_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // Request stream.
    input  wire logic                              i_s_axis_tvalid,
    output logic                                   o_s_axis_tready,
    // tdata from bit 0 up: key [31:0], value [95:32].
    input  wire logic [skvt_pkg::IN_DATA_W-1:0]    i_s_axis_tdata,
    // tuser: kind [1:0].
    input  wire logic [skvt_pkg::KIND_W-1:0]       i_s_axis_tuser,
    // Result stream.
    output logic                                   o_m_axis_tvalid,
    input  wire logic                              i_m_axis_tready,
    // tdata from bit 0 up: found_key [31:0], found_value [95:32],
    // entry_count [102:96], zero pad [103].
    output logic      [skvt_pkg::OUT_DATA_W-1:0]   o_m_axis_tdata,
    // tuser: ok [0].
    output logic                                   o_m_axis_tuser
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int KW = skvt_pkg::KEY_W;
    localparam int VW = skvt_pkg::VAL_W;
    localparam int EW = skvt_pkg::ENTRY_W;
    localparam int NW = skvt_pkg::COUNT_W;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_INS  = 5'b00010,
        ST_PUT  = 5'b00100,
        ST_SCAN = 5'b01000,
        ST_DONE = 5'b10000
    } t_state;

    // Control state.
    t_state          r_state, n_state;
    logic [CW-1:0]   r_occ, n_occ;
    logic            r_hit, n_hit;
    logic            r_ovalid, n_ovalid;

    // Request and result payload.
    skvt_pkg::t_kind r_kind, n_kind;
    logic [KW-1:0]   r_key, n_key;
    logic [VW-1:0]   r_value, n_value;
    logic [AW-1:0]   r_idx, n_idx;
    logic            r_res_ok, n_res_ok;
    logic [KW-1:0]   r_res_key, n_res_key;
    logic [VW-1:0]   r_res_val, n_res_val;
    logic [skvt_pkg::OUT_DATA_W-1:0] r_odata, n_odata;
    logic            r_ouser, n_ouser;

    // RAM port signals.
    logic            w_we;
    logic [AW-1:0]   w_waddr;
    logic [EW-1:0]   w_wdata;
    logic [AW-1:0]   w_raddr;
    logic [EW-1:0]   w_rdata;
    logic [KW-1:0]   w_rd_key;

    skvt_pkg::t_cmp  w_cmp;
    skvt_pkg::t_kind w_in_kind;
    logic [KW-1:0]   w_in_key;
    logic [VW-1:0]   w_in_value;
    logic [CW-1:0]   w_last;
    logic [AW-1:0]   w_last_idx;
    logic            w_at_last;
    logic [CW+NW-1:0] w_cnt_ext;

    skvt_ram #(
        .WIDTH (EW),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_rd_key = w_rdata[KW-1:0];

    // One comparator serves both the insert walk and the match scan.
    skvt_cmp u_cmp (
        .i_a   (w_rd_key),
        .i_b   (r_key),
        .o_cmp (w_cmp)
    );

    assign w_in_kind  = skvt_pkg::t_kind'(i_s_axis_tuser);
    assign w_in_key   = i_s_axis_tdata[KW-1:0];
    assign w_in_value = i_s_axis_tdata[KW+VW-1:KW];

    // Index of the last occupied entry; only used when the table is not empty.
    assign w_last     = r_occ - CW'(1);
    assign w_last_idx = w_last[AW-1:0];
    assign w_at_last  = (CW'(r_idx) == w_last);

    // Entry count as reported: the occupancy taken to the field's width.
    assign w_cnt_ext  = {{NW{1'b0}}, r_occ};

    always_comb begin
        n_state   = r_state;
        n_occ     = r_occ;
        n_hit     = r_hit;
        n_kind    = r_kind;
        n_key     = r_key;
        n_value   = r_value;
        n_idx     = r_idx;
        n_res_ok  = r_res_ok;
        n_res_key = r_res_key;
        n_res_val = r_res_val;
        n_ovalid  = r_ovalid && !i_m_axis_tready;
        n_odata   = r_odata;
        n_ouser   = r_ouser;
        w_we      = 1'b0;
        w_waddr   = '0;
        w_wdata   = {r_value, r_key};
        w_raddr   = '0;

        unique case (r_state)
            ST_IDLE: begin
                if (i_s_axis_tvalid) begin
                    n_kind    = w_in_kind;
                    n_key     = w_in_key;
                    n_value   = w_in_value;
                    n_res_ok  = 1'b0;
                    n_res_key = '0;
                    n_res_val = '0;
                    n_hit     = 1'b0;
                    n_state   = ST_DONE;
                    unique case (w_in_kind)
                        skvt_pkg::KIND_INSERT: begin
                            if (r_occ == CW'(CAPACITY)) begin
                                n_res_ok = 1'b0;
                            end else if (r_occ == '0) begin
                                // Empty table: the entry goes straight to the head.
                                w_we     = 1'b1;
                                w_waddr  = '0;
                                w_wdata  = {w_in_value, w_in_key};
                                n_occ    = CW'(1);
                                n_res_ok = 1'b1;
                            end else begin
                                w_raddr = w_last_idx;
                                n_idx   = w_last_idx;
                                n_state = ST_INS;
                            end
                        end
                        skvt_pkg::KIND_DELETE,
                        skvt_pkg::KIND_SEARCH: begin
                            if (r_occ != '0) begin
                                w_raddr = '0;
                                n_idx   = '0;
                                n_state = ST_SCAN;
                            end
                        end
                        skvt_pkg::KIND_CLEAR: begin
                            n_occ    = '0;
                            n_res_ok = 1'b1;
                        end
                    endcase
                end
            end

            ST_INS: begin
                // The entry at r_idx is on the read port.
                w_we    = 1'b1;
                w_waddr = r_idx + AW'(1);
                if (w_cmp.less) begin
                    // Found the slot just above a smaller key.
                    w_wdata  = {r_value, r_key};
                    n_occ    = r_occ + CW'(1);
                    n_res_ok = 1'b1;
                    n_state  = ST_DONE;
                end else begin
                    w_wdata = w_rdata;
                    if (r_idx == '0) begin
                        n_state = ST_PUT;
                    end else begin
                        w_raddr = r_idx - AW'(1);
                        n_idx   = r_idx - AW'(1);
                    end
                end
            end

            ST_PUT: begin
                // Every stored key was greater or equal: the entry becomes the head.
                w_we     = 1'b1;
                w_waddr  = '0;
                w_wdata  = {r_value, r_key};
                n_occ    = r_occ + CW'(1);
                n_res_ok = 1'b1;
                n_state  = ST_DONE;
            end

            ST_SCAN: begin
                if (r_hit) begin
                    // Delete after the match: close the gap one entry at a time.
                    w_we    = 1'b1;
                    w_waddr = r_idx - AW'(1);
                    w_wdata = w_rdata;
                end else if (w_cmp.eq) begin
                    n_res_ok  = 1'b1;
                    n_res_key = w_rd_key;
                    n_res_val = w_rdata[EW-1:KW];
                    n_hit     = 1'b1;
                end

                if (!r_hit && w_cmp.eq && r_kind == skvt_pkg::KIND_SEARCH) begin
                    n_state = ST_DONE;
                end else if (w_at_last) begin
                    if (r_hit || w_cmp.eq) begin
                        n_occ = r_occ - CW'(1);
                    end
                    n_state = ST_DONE;
                end else begin
                    w_raddr = r_idx + AW'(1);
                    n_idx   = r_idx + AW'(1);
                end
            end

            ST_DONE: begin
                if (!r_ovalid || i_m_axis_tready) begin
                    n_ovalid = 1'b1;
                    n_ouser  = r_res_ok;
                    n_odata  = {1'b0, w_cnt_ext[NW-1:0], r_res_val, r_res_key};
                    n_state  = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_occ    <= '0;
            r_hit    <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_occ    <= n_occ;
            r_hit    <= n_hit;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind    <= n_kind;
        r_key     <= n_key;
        r_value   <= n_value;
        r_idx     <= n_idx;
        r_res_ok  <= n_res_ok;
        r_res_key <= n_res_key;
        r_res_val <= n_res_val;
        r_odata   <= n_odata;
        r_ouser   <= n_ouser;
    end

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = r_odata;
    assign o_m_axis_tuser  = r_ouser;

endmodule

`default_nettype wire
